### hw/rtl/hem_pkg.sv
// Shared types, constants and microcode ROM for the heightmap extrusion block.
// Used by hem_useq, hem_dpath and the top level; no dependencies.
`default_nettype none
package hem_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_STEP_X       = 3'd2,
    CFG_STEP_Y       = 3'd3,
    CFG_FUDGE_X      = 3'd4,
    CFG_FUDGE_Y      = 3'd5
  } cfg_idx_t;

  localparam logic [8:0]  RST_FRAME_WIDTH  = 9'd64;
  localparam logic [8:0]  RST_FRAME_HEIGHT = 9'd64;
  localparam logic [17:0] RST_STEP_X       = 18'd2048;
  localparam logic [17:0] RST_STEP_Y       = 18'd2048;
  localparam logic [13:0] RST_FUDGE_X      = 14'd164;
  localparam logic [13:0] RST_FUDGE_Y      = 14'd164;

  localparam logic [8:0] MAX_WIDTH_C  = 9'(MAX_WIDTH);
  localparam logic [8:0] MAX_HEIGHT_C = 9'(MAX_HEIGHT);

  // depth = floor(n * DEPTH_RECIP / 2^DEPTH_SHIFT), n = (level-1)*65536 + 1270
  localparam int unsigned DEPTH_SHIFT     = 36;
  localparam logic [24:0] DEPTH_RECIP     = 25'd27054913;
  localparam logic [15:0] DEPTH_ROUND     = 16'd1270;
  localparam logic [17:0] POS_OFFSET      = 18'h10000;

  localparam int unsigned MUL_A_W = 24;
  localparam int unsigned MUL_B_W = 25;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic [8:0]  frame_width;
    logic [8:0]  frame_height;
    logic [17:0] step_x;
    logic [17:0] step_y;
    logic [13:0] fudge_x;
    logic [13:0] fudge_y;
  } cfg_t;

  typedef logic [4:0] step_t;

  typedef enum logic [1:0] {
    JMP_NONE   = 2'd0,
    JMP_WAIT   = 2'd1,
    JMP_EMPTY  = 2'd2,
    JMP_NOFACE = 2'd3
  } jmp_t;

  typedef enum logic [1:0] {
    MUL_NONE  = 2'd0,
    MUL_COL   = 2'd1,
    MUL_ROW   = 2'd2,
    MUL_DEPTH = 2'd3
  } mul_t;

  typedef enum logic [2:0] {
    FACE_FRONT  = 3'd0,
    FACE_LEFT   = 3'd1,
    FACE_RIGHT  = 3'd2,
    FACE_TOP    = 3'd3,
    FACE_BOTTOM = 3'd4
  } face_t;

  localparam step_t STEP_IDLE      = 5'd0;
  localparam step_t STEP_MUL_COL   = 5'd1;
  localparam step_t STEP_MUL_ROW   = 5'd2;
  localparam step_t STEP_MUL_DEPTH = 5'd3;
  localparam step_t STEP_CALC_A    = 5'd4;
  localparam step_t STEP_CALC_B    = 5'd5;
  localparam step_t STEP_EMIT      = 5'd6;
  localparam step_t STEP_END       = 5'd26;
  localparam step_t STEP_FACE_LEN  = 5'd4;

  typedef struct packed {
    logic        accept;
    mul_t        mul;
    logic        calc_a;
    logic        calc_b;
    logic        emit;
    logic [2:0]  face;
    logic [1:0]  corner;
    jmp_t        jmp;
    logic        jmp_always;
    step_t       target;
  } uword_t;

  typedef struct packed {
    logic        accept;
    mul_t        mul;
    logic        calc_a;
    logic        calc_b;
    logic        emit;
    logic [2:0]  face;
    logic [1:0]  corner;
  } ctl_t;

  typedef struct packed {
    logic        in_valid;
    logic        level_zero;
    logic        out_free;
    logic [4:0]  face_en;
  } stat_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    step_t  e;
    w = '0;
    e = step_t'(s - STEP_EMIT);
    case (s)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.jmp    = JMP_WAIT;
      end
      STEP_MUL_COL: begin
        w.mul    = MUL_COL;
        w.jmp    = JMP_EMPTY;
        w.target = STEP_IDLE;
      end
      STEP_MUL_ROW:   w.mul = MUL_ROW;
      STEP_MUL_DEPTH: w.mul = MUL_DEPTH;
      STEP_CALC_A:    w.calc_a = 1'b1;
      STEP_CALC_B:    w.calc_b = 1'b1;
      default: begin
        if (s >= STEP_EMIT && s < STEP_END) begin
          w.emit   = 1'b1;
          w.face   = e[4:2];
          w.corner = e[1:0];
          if (e[1:0] == 2'd0) begin
            w.jmp    = JMP_NOFACE;
            w.target = (e[4:2] == FACE_BOTTOM) ? STEP_IDLE : step_t'(s + STEP_FACE_LEN);
          end else if (s == step_t'(STEP_END - 5'd1)) begin
            w.jmp_always = 1'b1;
            w.target     = STEP_IDLE;
          end
        end else begin
          w.jmp_always = 1'b1;
          w.target     = STEP_IDLE;
        end
      end
    endcase
    return w;
  endfunction

  // corner offsets per face: x step, y step, z sign (1 = negative)
  function automatic logic corner_dx(logic [2:0] f, logic [1:0] c);
    case (f)
      FACE_LEFT:  return 1'b0;
      FACE_RIGHT: return 1'b1;
      default:    return c[1];
    endcase
  endfunction

  function automatic logic corner_dy(logic [2:0] f, logic [1:0] c);
    case (f)
      FACE_TOP:    return 1'b1;
      FACE_BOTTOM: return 1'b0;
      default:     return ~c[0];
    endcase
  endfunction

  function automatic logic corner_zneg(logic [2:0] f, logic [1:0] c);
    case (f)
      FACE_LEFT:   return c[1];
      FACE_RIGHT:  return ~c[1];
      FACE_TOP:    return c[0];
      FACE_BOTTOM: return ~c[0];
      default:     return 1'b0;
    endcase
  endfunction

  // (n+1)>>1, kept modulo 2^18
  function automatic logic [17:0] half18(logic [18:0] n);
    logic [18:0] s;
    s = n + 19'd1;
    return s[18:1];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/hem_in_if.sv
// Input channel of the heightmap extrusion block: one pixel with its neighbors.
// No dependencies.
`default_nettype none
interface hem_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] col;
  logic [7:0] row;
  logic [7:0] level;
  logic [7:0] left_level;
  logic [7:0] right_level;
  logic [7:0] upper_level;
  logic [7:0] lower_level;

  modport source (output valid, col, row, level, left_level, right_level, upper_level,
                  lower_level, input ready);
  modport sink   (input valid, col, row, level, left_level, right_level, upper_level,
                  lower_level, output ready);
  modport mon    (input valid, ready, col, row, level, left_level, right_level, upper_level,
                  lower_level);
endinterface
`default_nettype wire

### hw/rtl/hem_out_if.sv
// Result channel of the heightmap extrusion block: one mesh vertex per word.
// No dependencies.
`default_nettype none
interface hem_out_if;
  logic               valid;
  logic               ready;
  logic [20:0]        vertex_number;
  logic [2:0]         face;
  logic [1:0]         corner;
  logic signed [17:0] pos_x;
  logic signed [17:0] pos_y;
  logic signed [13:0] pos_z;
  logic signed [17:0] tex_u;
  logic signed [17:0] tex_v;
  logic               last;

  modport source (output valid, vertex_number, face, corner, pos_x, pos_y, pos_z, tex_u,
                  tex_v, last, input ready);
  modport sink   (input valid, vertex_number, face, corner, pos_x, pos_y, pos_z, tex_u,
                  tex_v, last, output ready);
  modport mon    (input valid, ready, vertex_number, face, corner, pos_x, pos_y, pos_z,
                  tex_u, tex_v, last);
endinterface
`default_nettype wire

### hw/rtl/hem_useq.sv
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on hem_pkg.
`default_nettype none
module hem_useq
  import hem_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  stat_t stat,
  output ctl_t  ctl
);

  step_t  step_r, step_nxt;
  uword_t uw;
  logic   skip, hold, taken;

  assign uw    = ucode(step_r);
  assign skip  = (uw.jmp == JMP_NOFACE) && !stat.face_en[uw.face];
  assign hold  = ((uw.jmp == JMP_WAIT) && !stat.in_valid) ||
                 (uw.emit && !skip && !stat.out_free);
  assign taken = uw.jmp_always || skip || ((uw.jmp == JMP_EMPTY) && stat.level_zero);

  always_comb begin
    if (hold) begin
      step_nxt = step_r;
    end else if (taken) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_t'(step_r + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctl.accept = uw.accept;
  assign ctl.mul    = uw.mul;
  assign ctl.calc_a = uw.calc_a;
  assign ctl.calc_b = uw.calc_b;
  assign ctl.emit   = uw.emit && !skip && stat.out_free;
  assign ctl.face   = uw.face;
  assign ctl.corner = uw.corner;

endmodule
`default_nettype wire

### hw/rtl/hem_dpath.sv
// Datapath: input capture, shared multiplier, coordinate registers, vertex
// counter and the output register. Depends on hem_pkg, hem_in_if, hem_out_if.
`default_nettype none
module hem_dpath
  import hem_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  cfg_t        cfg,
  input  ctl_t        ctl,
  output stat_t       stat,
  hem_in_if.sink      in_ch,
  hem_out_if.source   out_ch
);

  logic               in_fire;
  logic [8:0]         eff_w, eff_h;
  logic               big;
  logic [4:0]         face_en;

  logic [7:0]         col_r, row_r, lvl_r;
  logic [4:0]         faces_r;
  logic [20:0]        cnt_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  logic [7:0]         lvl_m1;

  logic [18:0]        cs_r, rs_r, cs1_r, rs1_r;
  logic [12:0]        d_r;
  logic [17:0]        u0_r, u1_r, v0_r, v1_r;

  logic               dx, dy, zneg, last;
  logic [4:0]         above;
  logic [18:0]        xs, ys;
  logic [13:0]        dz;

  logic               out_valid_r;
  logic [20:0]        vnum_r;
  logic [2:0]         face_r;
  logic [1:0]         corner_r;
  logic [17:0]        px_r, py_r, tu_r, tv_r;
  logic [13:0]        pz_r;
  logic               last_r;

  assign in_ch.ready = ctl.accept;
  assign in_fire     = in_ch.valid && ctl.accept;

  assign eff_w = (cfg.frame_width  > MAX_WIDTH_C)  ? MAX_WIDTH_C  : cfg.frame_width;
  assign eff_h = (cfg.frame_height > MAX_HEIGHT_C) ? MAX_HEIGHT_C : cfg.frame_height;
  assign big   = in_ch.level > 8'd1;

  assign face_en[FACE_FRONT]  = 1'b1;
  assign face_en[FACE_LEFT]   = big && (in_ch.col == 8'd0 || in_ch.left_level < in_ch.level);
  assign face_en[FACE_RIGHT]  = big && ({1'b0, in_ch.col} == 9'(eff_w - 9'd1) ||
                                        in_ch.right_level < in_ch.level);
  assign face_en[FACE_TOP]    = big && ({1'b0, in_ch.row} == 9'(eff_h - 9'd1) ||
                                        in_ch.upper_level < in_ch.level);
  assign face_en[FACE_BOTTOM] = big && (in_ch.row == 8'd0 || in_ch.lower_level < in_ch.level);

  // shared multiplier
  assign lvl_m1 = 8'(lvl_r - 8'd1);
  always_comb begin
    case (ctl.mul)
      MUL_COL: begin
        mul_a = MUL_A_W'(col_r);
        mul_b = MUL_B_W'(cfg.step_x);
      end
      MUL_ROW: begin
        mul_a = MUL_A_W'(row_r);
        mul_b = MUL_B_W'(cfg.step_y);
      end
      MUL_DEPTH: begin
        mul_a = {lvl_m1, DEPTH_ROUND};
        mul_b = DEPTH_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      col_r   <= in_ch.col;
      row_r   <= in_ch.row;
      lvl_r   <= in_ch.level;
      faces_r <= face_en;
    end
    case (ctl.mul)
      MUL_COL:   cs_r <= prod[18:0];
      MUL_ROW:   rs_r <= prod[18:0];
      MUL_DEPTH: d_r  <= prod[DEPTH_SHIFT+12:DEPTH_SHIFT];
      default: ;
    endcase
    if (ctl.calc_a) begin
      cs1_r <= cs_r + 19'(cfg.step_x);
      rs1_r <= rs_r + 19'(cfg.step_y);
      u0_r  <= half18(cs_r) + 18'(cfg.fudge_x);
      v1_r  <= half18(rs_r) + 18'(cfg.fudge_y);
    end
    if (ctl.calc_b) begin
      u1_r <= half18(cs1_r) - 18'(cfg.fudge_x);
      v0_r <= half18(rs1_r) - 18'(cfg.fudge_y);
    end
  end

  // vertex fields
  assign dx    = corner_dx(ctl.face, ctl.corner);
  assign dy    = corner_dy(ctl.face, ctl.corner);
  assign zneg  = corner_zneg(ctl.face, ctl.corner);
  assign xs    = dx ? cs1_r : cs_r;
  assign ys    = dy ? rs1_r : rs_r;
  assign dz    = zneg ? 14'(-{1'b0, d_r}) : {1'b0, d_r};
  assign above = (faces_r >> ctl.face) >> 1;
  assign last  = (ctl.corner == 2'd3) && (above == 5'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire && in_ch.col == 8'd0 && in_ch.row == 8'd0) begin
        cnt_r <= '0;
      end else if (ctl.emit) begin
        cnt_r <= cnt_r + 21'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      vnum_r   <= cnt_r;
      face_r   <= ctl.face;
      corner_r <= ctl.corner;
      px_r     <= xs[17:0] - POS_OFFSET;
      py_r     <= ys[17:0] - POS_OFFSET;
      pz_r     <= dz;
      tu_r     <= ctl.corner[1] ? u1_r : u0_r;
      tv_r     <= ctl.corner[0] ? v1_r : v0_r;
      last_r   <= last;
    end
  end

  assign stat.in_valid   = in_ch.valid;
  assign stat.level_zero = (lvl_r == 8'd0);
  assign stat.out_free   = !out_valid_r || out_ch.ready;
  assign stat.face_en    = faces_r;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.vertex_number = vnum_r;
  assign out_ch.face          = face_r;
  assign out_ch.corner        = corner_r;
  assign out_ch.pos_x         = px_r;
  assign out_ch.pos_y         = py_r;
  assign out_ch.pos_z         = pz_r;
  assign out_ch.tex_u         = tu_r;
  assign out_ch.tex_v         = tv_r;
  assign out_ch.last          = last_r;

endmodule
`default_nettype wire

### hw/rtl/heightmap_extrude_mesh.sv
// Heightmap extrusion: turns thickness pixels into mesh vertices.
// Usage:
//   in_ch  takes one pixel (col, row, level and four neighbor levels) per word,
//          column-major. out_ch gives one vertex per word; last marks the
//          final vertex of a pixel. Both are valid/ready channels.
//   cfg_we/cfg_index/cfg_data write the frame size, steps and texture insets;
//          write only while the block is idle.
// Sequence:
//   An empty pixel (level 0) gives no vertex; the sequencer returns to idle
//   from the column product step. Otherwise the shared multiplier runs three
//   products and two add steps, then the microcode walks five faces of four
//   corners: one vertex per cycle for an emitted face unless out_ch.ready
//   stalls it, and a jump past each skipped face. The first vertex is
//   registered after the column, row and depth products and both add steps.
//   The next pixel is taken once the last vertex sits in the output register.
// Reset: synchronous, clears the step counter, output valid and the vertex
//   count; the config registers return to their defaults.
// Stall: a low out_ch.ready holds the sequencer on the pending vertex.
// Depends on hem_pkg, hem_in_if, hem_out_if, hem_useq, hem_dpath.
`default_nettype none
module heightmap_extrude_mesh
  import hem_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  hem_in_if.sink                in_ch,
  hem_out_if.source             out_ch,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t  cfg_r;
  ctl_t  ctl;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= RST_FRAME_WIDTH;
      cfg_r.frame_height <= RST_FRAME_HEIGHT;
      cfg_r.step_x       <= RST_STEP_X;
      cfg_r.step_y       <= RST_STEP_Y;
      cfg_r.fudge_x      <= RST_FUDGE_X;
      cfg_r.fudge_y      <= RST_FUDGE_Y;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data[8:0];
        CFG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data[8:0];
        CFG_STEP_X:       cfg_r.step_x       <= cfg_data;
        CFG_STEP_Y:       cfg_r.step_y       <= cfg_data;
        CFG_FUDGE_X:      cfg_r.fudge_x      <= cfg_data[13:0];
        CFG_FUDGE_Y:      cfg_r.fudge_y      <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  hem_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  hem_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .ctl    (ctl),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

### hw/rtl/hem_chk.sv
// Port-level checker for heightmap_extrude_mesh, bound to the top level.
// Takes the handshake and a few result fields of the top level's channels.
`default_nettype none
module hem_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [20:0] out_vertex_number,
  input wire [1:0]  out_corner,
  input wire        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_number))
    else $error("result word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted word");

  a_busy_mid_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("new pixel taken before its vertices were all sent");

  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_corner == 2'd3)
    else $error("last flag on a corner other than the fourth");

endmodule

bind heightmap_extrude_mesh hem_chk u_hem_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_vertex_number (out_ch.vertex_number),
  .out_corner        (out_ch.corner),
  .out_last          (out_ch.last)
);
`default_nettype wire

### bench/heightmap_extrude_mesh_test.sv
`timescale 1ns / 1ps
// Testbench for heightmap_extrude_mesh: directed pixels, then scans of random heightmaps
// under several frame settings; every vertex word is checked against an in-bench predictor.
// Depends on hem_pkg, hem_in_if, hem_out_if and the block itself.
module heightmap_extrude_mesh_test;
  import hem_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_PIXELS   = 30;
  localparam int MAX_REPORTS    = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] level;
    logic [7:0] left;
    logic [7:0] right;
    logic [7:0] upper;
    logic [7:0] lower;
  } pixel_t;

  typedef struct {
    logic [20:0]        number;
    logic [2:0]         face;
    logic [1:0]         corner;
    logic signed [17:0] px;
    logic signed [17:0] py;
    logic signed [13:0] pz;
    logic signed [17:0] u;
    logic signed [17:0] v;
    logic               last;
  } vertex_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hem_in_if  in_ch();
  hem_out_if out_ch();

  heightmap_extrude_mesh dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_t      pending_pixels[$];
  vertex_t     expected_vertices[$];
  pixel_t      offered;
  logic [8:0]  cur_width, cur_height;
  logic [17:0] cur_step_x, cur_step_y;
  logic [13:0] cur_inset_x, cur_inset_y;
  logic [20:0] next_vertex;
  bit          calm = 1'b0;
  int          holds_asked = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          pixels_sent = 0;
  int          vertices_seen = 0;
  int          settings_applied = 0;
  int          quiet_cycles = 0;

  // {x step, y step, z negative}, one bit per corner
  function automatic logic [11:0] corner_masks(face_t f);
    case (f)
      FACE_FRONT: return {4'b1100, 4'b0101, 4'b0000};
      FACE_LEFT:  return {4'b0000, 4'b0101, 4'b1100};
      FACE_RIGHT: return {4'b1111, 4'b0101, 4'b0011};
      FACE_TOP:   return {4'b1100, 4'b1111, 4'b1010};
      default:    return {4'b1100, 4'b0000, 4'b0101};
    endcase
  endfunction

  task automatic extrude_pixel(input pixel_t p);
    longint  col, row, sx, sy, ix, iy, x, y, depth, u0, u1, v0, v1, ew, eh;
    logic [4:0]  faces;
    logic [11:0] m;
    int      total, k, f, c;
    vertex_t vtx;
    col = p.col;
    row = p.row;
    sx  = cur_step_x;
    sy  = cur_step_y;
    ix  = cur_inset_x;
    iy  = cur_inset_y;
    ew  = (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
    eh  = (cur_height > MAX_HEIGHT) ? MAX_HEIGHT : cur_height;
    if (p.col == 8'd0 && p.row == 8'd0) next_vertex = '0;
    if (p.level == 8'd0) return;
    x     = col * sx - 65536;
    y     = row * sy - 65536;
    depth = ((longint'(p.level) - 1) * 65536 + 1270) / 2540;
    u0    = (col * sx + 1) / 2 + ix;
    u1    = ((col + 1) * sx + 1) / 2 - ix;
    v0    = ((row + 1) * sy + 1) / 2 - iy;
    v1    = (row * sy + 1) / 2 + iy;
    faces[FACE_FRONT]  = 1'b1;
    faces[FACE_LEFT]   = p.level > 8'd1 && (col == 0 || p.left < p.level);
    faces[FACE_RIGHT]  = p.level > 8'd1 && (col == ew - 1 || p.right < p.level);
    faces[FACE_TOP]    = p.level > 8'd1 && (row == eh - 1 || p.upper < p.level);
    faces[FACE_BOTTOM] = p.level > 8'd1 && (row == 0 || p.lower < p.level);
    total = 4 * $countones(faces);
    k = 0;
    for (f = 0; f < 5; f++) begin
      if (faces[f]) begin
        m = corner_masks(face_t'(f));
        for (c = 0; c < 4; c++) begin
          vtx.number = next_vertex;
          vtx.face   = 3'(f);
          vtx.corner = 2'(c);
          vtx.px     = 18'(x + (m[8+c] ? sx : 0));
          vtx.py     = 18'(y + (m[4+c] ? sy : 0));
          vtx.pz     = 14'(m[c] ? -depth : depth);
          vtx.u      = 18'(c < 2 ? u0 : u1);
          vtx.v      = 18'((c % 2 == 1) ? v1 : v0);
          vtx.last   = (k == total - 1);
          expected_vertices.insert(expected_vertices.size(), vtx);
          next_vertex = next_vertex + 21'd1;
          k++;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] vertex word %0d: %s", $time, vertices_seen, msg);
  endtask

  task automatic compare_field(input string what, input logic signed [31:0] got,
                               input logic signed [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", what, got, want));
  endtask

  // input side
  always @(posedge clk) begin : driver
    bit keep;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      keep = in_ch.valid && !in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        extrude_pixel(offered);
        pixels_sent++;
      end
      if (!keep) begin
        if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
          offered = pending_pixels.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.col         <= offered.col;
          in_ch.row         <= offered.row;
          in_ch.level       <= offered.level;
          in_ch.left_level  <= offered.left;
          in_ch.right_level <= offered.right;
          in_ch.upper_level <= offered.upper;
          in_ch.lower_level <= offered.lower;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin : monitor
    vertex_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_vertices.size() == 0) begin
          report_mismatch("word arrived with nothing expected");
        end else begin
          want = expected_vertices.pop_front();
          compare_field("vertex_number", out_ch.vertex_number, want.number);
          compare_field("face", out_ch.face, want.face);
          compare_field("corner", out_ch.corner, want.corner);
          compare_field("pos_x", out_ch.pos_x, want.px);
          compare_field("pos_y", out_ch.pos_y, want.py);
          compare_field("pos_z", out_ch.pos_z, want.pz);
          compare_field("tex_u", out_ch.tex_u, want.u);
          compare_field("tex_v", out_ch.tex_v, want.v);
          compare_field("last", out_ch.last, want.last);
        end
        vertices_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || $urandom_range(99) >= 14;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("no word moved for %0d cycles, giving up", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_level();
    int roll;
    roll = $urandom_range(9);
    case (roll)
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      3, 4, 5: return 8'($urandom_range(1, 4));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_pixel(input logic [7:0] c, r, lv, l, rt, u, lo);
    pending_pixels.insert(pending_pixels.size(), {c, r, lv, l, rt, u, lo});
  endtask

  // scan of a small window of a random heightmap, neighbors taken from the same map
  task automatic queue_window(inout int queued);
    logic [7:0] grid [0:6][0:7];
    int span_w, span_h, nc, nr, c0, r0, ci, ri, where;
    span_w = (cur_width == 0 || cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
    span_h = (cur_height == 0 || cur_height > MAX_HEIGHT) ? MAX_HEIGHT : cur_height;
    nc = $urandom_range(1, span_w < 5 ? span_w : 5);
    nr = $urandom_range(1, span_h < 6 ? span_h : 6);
    where = $urandom_range(9);
    c0 = (where < 5) ? 0 : (where < 8) ? span_w - nc : $urandom_range(span_w - nc);
    r0 = (where < 5) ? 0 : (where < 8) ? span_h - nr : $urandom_range(span_h - nr);
    foreach (grid[i, j]) grid[i][j] = pick_level();
    for (ci = 0; ci < nc; ci++) begin
      for (ri = 0; ri < nr; ri++) begin
        queue_pixel(8'(c0 + ci), 8'(r0 + ri), grid[ci+1][ri+1], grid[ci][ri+1],
                    grid[ci+2][ri+1], grid[ci+1][ri+2], grid[ci+1][ri]);
        queued++;
      end
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_FRAME_WIDTH:  cur_width   = value[8:0];
      CFG_FRAME_HEIGHT: cur_height  = value[8:0];
      CFG_STEP_X:       cur_step_x  = value[17:0];
      CFG_STEP_Y:       cur_step_y  = value[17:0];
      CFG_FUDGE_X:      cur_inset_x = value[13:0];
      CFG_FUDGE_Y:      cur_inset_y = value[13:0];
      default: ;
    endcase
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_ch.valid || expected_vertices.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [8:0] w, h, input logic [17:0] sx, sy,
                           input logic [13:0] fx, fy, input bit no_idle, input bit hold);
    int queued;
    wait_until_drained();
    write_register(CFG_FRAME_WIDTH, 18'(w));
    write_register(CFG_FRAME_HEIGHT, 18'(h));
    write_register(CFG_STEP_X, sx);
    write_register(CFG_STEP_Y, sy);
    write_register(CFG_FUDGE_X, 18'(fx));
    write_register(CFG_FUDGE_Y, 18'(fy));
    @(posedge clk) cfg_we <= 1'b0;
    @(negedge clk);
    calm = no_idle;
    if (hold) holds_asked++;
    queued = 0;
    while (queued < PHASE_PIXELS) begin
      if ($urandom_range(99) < 20) begin
        queue_pixel(8'($urandom), 8'($urandom), pick_level(), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
        queued++;
      end else begin
        queue_window(queued);
      end
    end
    settings_applied++;
  endtask

  initial begin : stimulus
    int          i;
    logic [8:0]  w, h;
    logic [17:0] sx, sy;
    in_ch.valid       = 1'b0;
    in_ch.col         = '0;
    in_ch.row         = '0;
    in_ch.level       = '0;
    in_ch.left_level  = '0;
    in_ch.right_level = '0;
    in_ch.upper_level = '0;
    in_ch.lower_level = '0;
    out_ch.ready      = 1'b0;
    cur_width   = RST_FRAME_WIDTH;
    cur_height  = RST_FRAME_HEIGHT;
    cur_step_x  = RST_STEP_X;
    cur_step_y  = RST_STEP_Y;
    cur_inset_x = RST_FUDGE_X;
    cur_inset_y = RST_FUDGE_Y;
    next_vertex = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // unused index must leave every register alone
    write_register(CFG_UNUSED, '1);
    @(posedge clk) cfg_we <= 1'b0;
    @(negedge clk);

    // directed pixels at the reset frame of 64 x 64
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd9, 8'd9, 8'd9, 8'd9);         // frame start, empty
    queue_pixel(8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0);         // flat
    queue_pixel(8'd0, 8'd2, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);       // all five faces
    queue_pixel(8'd0, 8'd3, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2);         // equal neighbors
    queue_pixel(8'd1, 8'd4, 8'd5, 8'd9, 8'd9, 8'd9, 8'd9);         // higher neighbors
    queue_pixel(8'd63, 8'd63, 8'd7, 8'd255, 8'd255, 8'd255, 8'd255); // right and top border
    queue_pixel(8'd100, 8'd0, 8'd128, 8'd200, 8'd200, 8'd200, 8'd200); // bottom border
    queue_pixel(8'd10, 8'd10, 8'd2, 8'd1, 8'd2, 8'd1, 8'd2);
    queue_pixel(8'd10, 8'd11, 8'd2, 8'd2, 8'd1, 8'd2, 8'd1);
    queue_pixel(8'd5, 8'd5, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0);         // flat, lower neighbors
    queue_pixel(8'd0, 8'd0, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0);         // frame restart
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);         // restart, empty
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255); // beyond frame
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    queue_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
    queue_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
    queue_pixel(8'd64, 8'd64, 8'd254, 8'd253, 8'd255, 8'd0, 8'd254);
    queue_pixel(8'd62, 8'd62, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1);

    run_phase(9'd1, 9'd1, 18'd131072, 18'd131072, 14'd0, 14'd0, 1'b0, 1'b0);
    run_phase(9'd256, 9'd256, 18'd512, 18'd512, 14'd10486, 14'd10486, 1'b0, 1'b1);
    run_phase(9'd0, 9'd511, 18'h3FFFF, 18'h3FFFF, 14'h3FFF, 14'h3FFF, 1'b0, 1'b0);
    for (i = 0; i < 6; i++) begin
      w  = 9'((i == 5) ? $urandom_range(100, 256) : $urandom_range(2, 8));
      h  = 9'((i == 4) ? $urandom_range(100, 256) : $urandom_range(2, 8));
      sx = 18'(131072 / w);
      sy = 18'(131072 / h);
      run_phase(w, h, sx, sy, 14'($urandom_range(sx / 8)), 14'($urandom_range(sy / 8)),
                i == 2, 1'b0);
    end
    wait_until_drained();

    $display("Ran %0d pixels through %0d frame settings; %0d vertex words checked.",
             pixels_sent, settings_applied, vertices_seen);
    $display("Border, flat, empty and restart pixels, output hold-off and idle gaps: %0d errors.",
             mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
